@@ sv/whss_pkg.sv @@
// Shared constants, command/status types and helper functions for socket steering.
`default_nettype none

package whss_pkg;

  localparam int SOCKETS    = 8;
  localparam int MAX_WEIGHT = 8;
  localparam int SLOTS      = 64;

  // only sockets below 8 have a weight nibble
  localparam int SOCK_N  = (SOCKETS < 8) ? SOCKETS : 8;
  localparam int SOCK_IW = $clog2(SOCK_N);
  localparam int SOCK_W  = $clog2(SOCK_N + 1);
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int HASH_W  = 32;
  localparam int ELIG_W  = 8;
  localparam int MODE_W  = 2;
  localparam int WGT_W   = 4;
  localparam int CFG_W   = 32;
  localparam int DIV_CW  = $clog2(HASH_W);

  localparam logic [CFG_W-1:0] WEIGHTS_RST = 32'h1111_1111;

  localparam logic [MODE_W-1:0] MODE_BCAST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

  typedef struct packed {
    logic load;
    logic bcast;
    logic build_start;
    logic build_step;
    logic red_start;
    logic use_second;
    logic div_step;
    logic rd_en;
    logic acc;
    logic out_load;
  } whss_cmd_t;

  typedef struct packed {
    logic steer;
    logic dbl;
    logic mismatch;
    logic build_done;
    logic count_zero;
    logic need_div;
    logic div_last;
  } whss_sts_t;

  function automatic logic [HASH_W-1:0] fold_bytes(input logic [HASH_W-1:0] h);
    fold_bytes = h ^ (h >> 8) ^ (h >> 16) ^ (h >> 24);
  endfunction

  // slot counts that always take the modulo path
  function automatic logic needs_mod(input logic [CNT_W-1:0] n);
    needs_mod = (n == CNT_W'(3)) || (n == CNT_W'(5)) || (n == CNT_W'(6)) ||
                (n == CNT_W'(7));
  endfunction

  // all ones from the top set bit of x downwards
  function automatic logic [CNT_W-1:0] smear(input logic [CNT_W-1:0] x);
    logic [CNT_W-1:0] y;
    y = x;
    for (int i = 1; i < CNT_W; i++) begin
      y = y | (y >> i);
    end
    smear = y;
  endfunction

endpackage

`default_nettype wire

@@ sv/whss_dp.sv @@
// Datapath: input capture, weight register, slot table, slot reduction and result registers.
`default_nettype none

module whss_dp (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [whss_pkg::CFG_W-1:0]    cfg_wdata_i,
  output logic [whss_pkg::CFG_W-1:0]    weights_o,
  input  wire  [whss_pkg::ELIG_W-1:0]   elig_i,
  input  wire  [whss_pkg::HASH_W-1:0]   flow_hash_i,
  input  wire  [whss_pkg::HASH_W-1:0]   second_hash_i,
  input  wire  [whss_pkg::MODE_W-1:0]   fanout_mode_i,
  input  whss_pkg::whss_cmd_t           cmd_i,
  output whss_pkg::whss_sts_t           sts_o,
  output logic [whss_pkg::ELIG_W-1:0]   dest_mask_o
);
  import whss_pkg::*;

  logic [CFG_W-1:0]   weights_q;
  logic [ELIG_W-1:0]  cached_q;
  logic [CNT_W-1:0]   cnt_q;

  logic [ELIG_W-1:0]  elig_q;
  logic [HASH_W-1:0]  h1_q, h2_q;
  logic [MODE_W-1:0]  mode_q;

  logic [SOCK_W-1:0]  sock_q;
  logic [WGT_W-1:0]   rep_q;

  logic [HASH_W-1:0]  quo_q;
  logic [CNT_W-1:0]   rem_q;
  logic [DIV_CW-1:0]  div_cnt_q;
  logic [IDX_W-1:0]   idx_q;

  logic [SOCK_IW-1:0] slot_mem [SLOTS];
  logic [SOCK_IW-1:0] rd_q;
  logic [ELIG_W-1:0]  mask_q;
  logic [ELIG_W-1:0]  out_q;

  // rebuild step
  logic [SOCK_IW-1:0] sidx;
  logic [WGT_W-1:0]   nib, wgt;
  logic               slot_wr;

  // slot reduction
  logic [HASH_W-1:0]  f;
  logic [CNT_W-1:0]   nm1, pm1, r;
  logic               pow2;
  logic [CNT_W:0]     t_sh, t_sub;

  always_comb begin
    sidx    = sock_q[SOCK_IW-1:0];
    nib     = weights_q[WGT_W*sidx +: WGT_W];
    wgt     = (nib > WGT_W'(MAX_WEIGHT)) ? WGT_W'(MAX_WEIGHT) : nib;
    slot_wr = cmd_i.build_step && (sock_q != SOCK_W'(SOCK_N)) && elig_q[sidx] &&
              (rep_q < wgt) && (cnt_q < CNT_W'(SLOTS));

    f    = fold_bytes(cmd_i.use_second ? h2_q : h1_q);
    nm1  = cnt_q - CNT_W'(1);
    pow2 = (cnt_q & nm1) == '0;
    pm1  = smear(nm1);
    r    = f[CNT_W-1:0] & pm1;

    t_sh  = {rem_q, quo_q[HASH_W-1]};
    t_sub = (t_sh >= {1'b0, cnt_q}) ? (t_sh - {1'b0, cnt_q}) : t_sh;
  end

  always_comb begin
    sts_o.steer      = (mode_q == MODE_SINGLE) || (mode_q == MODE_DOUBLE);
    sts_o.dbl        = mode_q == MODE_DOUBLE;
    sts_o.mismatch   = elig_q != cached_q;
    sts_o.build_done = sock_q == SOCK_W'(SOCK_N);
    sts_o.count_zero = cnt_q == '0;
    sts_o.need_div   = !pow2 && (needs_mod(cnt_q) || (r >= cnt_q));
    sts_o.div_last   = div_cnt_q == DIV_CW'(HASH_W - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q <= WEIGHTS_RST;
      cached_q  <= '0;
      cnt_q     <= '0;
    end else if (cfg_we_i) begin
      weights_q <= cfg_wdata_i;
      cached_q  <= '0;
      cnt_q     <= '0;
    end else if (cmd_i.build_start) begin
      cached_q  <= elig_q;
      cnt_q     <= '0;
    end else if (slot_wr) begin
      cnt_q     <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      elig_q <= elig_i;
      h1_q   <= flow_hash_i;
      h2_q   <= second_hash_i;
      mode_q <= fanout_mode_i;
      mask_q <= '0;
    end else if (cmd_i.bcast) begin
      mask_q <= elig_q;
    end else if (cmd_i.acc) begin
      mask_q <= mask_q | (ELIG_W'(1) << rd_q);
    end

    if (cmd_i.build_start) begin
      sock_q <= '0;
      rep_q  <= '0;
    end else if (cmd_i.build_step && !sts_o.build_done) begin
      if (slot_wr) begin
        rep_q <= rep_q + WGT_W'(1);
      end else begin
        sock_q <= sock_q + SOCK_W'(1);
        rep_q  <= '0;
      end
    end

    if (cmd_i.red_start) begin
      quo_q     <= f;
      rem_q     <= '0;
      div_cnt_q <= '0;
      idx_q     <= r[IDX_W-1:0];
    end else if (cmd_i.div_step) begin
      quo_q     <= quo_q << 1;
      rem_q     <= t_sub[CNT_W-1:0];
      div_cnt_q <= div_cnt_q + DIV_CW'(1);
      if (sts_o.div_last) begin
        idx_q <= t_sub[IDX_W-1:0];
      end
    end

    if (slot_wr) begin
      slot_mem[cnt_q[IDX_W-1:0]] <= sidx;
    end
    if (cmd_i.rd_en) begin
      rd_q <= slot_mem[idx_q];
    end

    if (cmd_i.out_load) begin
      out_q <= mask_q;
    end
  end

  assign weights_o   = weights_q;
  assign dest_mask_o = out_q;

`ifndef NO_ASSERTIONS
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (cnt_q == '0) && (cached_q == '0))
    else $error("config write did not clear the slot cache");
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> ({1'b0, idx_q} < {1'b0, cnt_q}))
    else $error("slot read beyond slot count");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < cnt_q))
    else $error("remainder not below slot count");
`endif

endmodule

`default_nettype wire

@@ sv/whss_ctrl.sv @@
// Controller: per-packet sequencing of rebuild, reduction, table read and result handoff.
`default_nettype none

module whss_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  whss_pkg::whss_sts_t  sts_i,
  output whss_pkg::whss_cmd_t  cmd_o
);
  import whss_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_BUILD, ST_START, ST_DIV, ST_READ, ST_ACC, ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   second_q, second_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    second_d    = second_q;
    in_ready_o  = state_q == ST_IDLE;
    cmd_o.use_second = second_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        second_d = 1'b0;
        if (!sts_i.steer) begin
          cmd_o.bcast = 1'b1;
          state_d     = ST_FINISH;
        end else if (sts_i.mismatch) begin
          cmd_o.build_start = 1'b1;
          state_d           = ST_BUILD;
        end else begin
          state_d = ST_START;
        end
      end
      ST_BUILD: begin
        if (sts_i.build_done) begin
          state_d = ST_START;
        end else begin
          cmd_o.build_step = 1'b1;
        end
      end
      ST_START: begin
        if (sts_i.count_zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.red_start = 1'b1;
          state_d         = sts_i.need_div ? ST_DIV : ST_READ;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (sts_i.dbl && !second_q) begin
          second_d = 1'b1;
          state_d  = ST_START;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_build_steer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUILD) |-> sts_i.steer)
    else $error("table rebuild for a broadcast packet");
  a_second_dbl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (second_q && (state_q == ST_START)) |-> sts_i.dbl)
    else $error("second pick outside double steering");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result load did not raise valid");
`endif

endmodule

`default_nettype wire

@@ sv/weighted_hash_socket_steering.sv @@
// Top level: weighted hash socket steering with stream ports and register port.
// Per packet: broadcast loads the eligible mask directly; single steering makes one
// pick, using the bit-serial remainder when needed; double steering adds a second pick;
// a table rebuild (one slot write or socket skip per cycle) runs first on a cache miss.
// One packet at a time: the next word is accepted in the cycle after the result loads.
// Reset: asynchronous, active low; weights 0x11111111, slot cache empty.
`default_nettype none

module weighted_hash_socket_steering (
  input  wire         clk_i,
  input  wire         rst_ni,
  // slave stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [71:0] s_axis_tdata,  // eligible_sockets[7:0], flow_hash[39:8], second_hash[71:40]
  input  wire  [1:0]  s_axis_tuser,  // fanout_mode[1:0]
  // master stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // dest_mask[7:0]
  // register port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import whss_pkg::*;

  whss_cmd_t        cmd;
  whss_sts_t        sts;
  logic             cfg_we;
  logic [CFG_W-1:0] weights;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : weights;

  whss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  whss_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (pwdata),
    .weights_o     (weights),
    .elig_i        (s_axis_tdata[7:0]),
    .flow_hash_i   (s_axis_tdata[39:8]),
    .second_hash_i (s_axis_tdata[71:40]),
    .fanout_mode_i (s_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .dest_mask_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire
